FILE: hdl/stsd_pkg.sv
`default_nettype none

package stsd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int PROD_W = 68;
  localparam int OPND_W = 34;
  localparam int TAYLOR_TERMS = 12;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [1:0] REG_DEGREES_FREEDOM = 2'd0;
  localparam logic [1:0] REG_AR_CONSTANT = 2'd1;
  localparam logic [1:0] REG_AR_COEFFICIENT = 2'd2;

  localparam logic [31:0] DOF_RESET = 32'd327680;

  // Reciprocals floor((2^32 - 1) / n) for the Taylor term divisors.
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd1: r = 32'd4294967295;
      4'd2: r = 32'd2147483647;
      4'd3: r = 32'd1431655765;
      4'd4: r = 32'd1073741823;
      4'd5: r = 32'd858993459;
      4'd6: r = 32'd715827882;
      4'd7: r = 32'd613566756;
      4'd8: r = 32'd536870911;
      4'd9: r = 32'd477218588;
      4'd10: r = 32'd429496729;
      4'd11: r = 32'd390451572;
      4'd12: r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/student_t_sv_score_derivatives.sv
// The result is computed with one shared 34x34 multiplier that is used once a cycle,
// a 12-term exponential series (each term takes a multiply, a reciprocal multiply and
// a correction step) and a 16-step restoring divider.
// The input is not ready while an item is at work, and a result that waits for its
// transfer holds the sequencer in its last step.
// Reset: synchronous, clears the sequencer, the result valid flag, the previous observation
// and loads the register reset values.
`default_nettype none

module student_t_sv_score_derivatives (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire logic signed [31:0]  observation,
  input  wire logic signed [31:0]  log_variance,
  input  wire logic                first_sample,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic signed [31:0]       deriv_first,
  output logic signed [31:0]       deriv_second,
  output logic signed [31:0]       deriv_third,
  output logic signed [31:0]       deriv_fourth,
  output logic signed [31:0]       deriv_fifth
);
  import stsd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_BP, S_RES, S_SQ, S_T, S_G, S_TG, S_TMUL, S_TREC, S_TCOR,
    S_SCALE, S_WLO, S_WHI, S_WSUM, S_DIV, S_P, S_UU, S_UUU, S_CP, S_CU,
    S_D3, S_D4, S_D5, S_FIN
  } state_t;

  state_t state;

  logic [31:0] dof;
  logic signed [31:0] ar_a;
  logic signed [31:0] ar_b;
  logic signed [31:0] prev_obs;

  logic signed [31:0] y;
  logic signed [31:0] alpha;
  logic signed [31:0] prev;
  logic signed [31:0] e;
  logic [46:0] esq;
  logic signed [17:0] k;
  logic [29:0] g;
  logic [30:0] term;
  logic [30:0] xr;
  logic [31:0] sum;
  logic [3:0] n;
  logic [30:0] ex;
  logic signed [PROD_W-1:0] acc;
  logic [62:0] den;
  logic [63:0] rem;
  logic [15:0] u;
  logic [3:0] cnt;
  logic [15:0] p;
  logic [15:0] uu;
  logic [15:0] uuu;
  logic [31:0] cp;
  logic signed [31:0] d1;
  logic signed [31:0] d3;
  logic signed [31:0] d4;

  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] ma;
  logic signed [OPND_W-1:0] mb;
  logic launch;

  logic [31:0] nu;
  logic [31:0] c;
  logic [31:0] mag;
  logic signed [23:0] q3;
  logic signed [23:0] q4;
  logic signed [23:0] q5;
  logic signed [PROD_W-1:0] prod_asr;
  logic signed [PROD_W-1:0] resid;
  logic [30:0] q0;
  logic [35:0] rchk;
  logic [30:0] term_new;
  logic signed [18:0] s;
  logic signed [18:0] ns;
  logic [62:0] sum_shl;
  logic [30:0] ex_new;
  logic [77:0] wsum;
  logic [62:0] w;
  logic [63:0] rem2;

  assign cfg_ready = 1'b1;
  assign item_ready = (state == S_IDLE);

  assign nu = (dof == 32'd0) ? 32'd1 : dof;
  assign c = 32'((33'(nu) + 33'd65536) >> 1);
  assign mag = e[31] ? 32'(-33'(e)) : 32'(e);
  assign prod_asr = prod >>> FRAC_BITS;
  assign q3 = 24'sd65536 - 24'(2 * 24'(u));
  assign q4 = 24'sd65536 - 24'(6 * 24'(u)) + 24'(6 * 24'(uu));
  assign q5 = 24'sd65536 - 24'(14 * 24'(u)) + 24'(36 * 24'(uu)) - 24'(24 * 24'(uuu));
  assign resid = PROD_W'(y) - PROD_W'(ar_a) - prod_asr;
  assign q0 = prod[62:32];
  assign rchk = 36'(xr) - 36'(q0) * 36'(n);
  assign term_new = (rchk >= 36'(n)) ? q0 + 31'd1 : q0;
  assign s = 19'(k) - 19'sd14;
  assign ns = -s;
  assign sum_shl = 63'(sum) << s[4:0];
  assign wsum = 78'(acc) + (78'(prod) << 23);
  assign w = (wsum > (78'd1 << 62)) ? (63'd1 << 62) : 63'(wsum >> FRAC_BITS);
  assign rem2 = {rem[62:0], 1'b0};

  always_comb begin
    if (!s[18]) begin
      if (s >= 19'sd31) begin
        ex_new = 31'h7FFFFFFF;
      end else if (sum > (32'h7FFFFFFF >> s[4:0])) begin
        ex_new = 31'h7FFFFFFF;
      end else begin
        ex_new = sum_shl[30:0];
      end
    end else begin
      if (ns >= 19'sd40) begin
        ex_new = 31'd0;
      end else begin
        ex_new = 31'(sum >> ns[5:0]);
      end
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    launch = 1'b1;
    case (state)
      S_BP: begin
        ma = OPND_W'(ar_b);
        mb = OPND_W'(prev);
      end
      S_SQ: begin
        ma = OPND_W'({2'b00, mag});
        mb = OPND_W'({2'b00, mag});
      end
      S_T: begin
        ma = -OPND_W'(alpha);
        mb = OPND_W'({3'b000, LOG2E_Q30});
      end
      S_G: begin
        ma = OPND_W'({4'b0000, prod[45:16]});
        mb = OPND_W'({4'b0000, LN2_Q30});
      end
      S_TMUL: begin
        ma = OPND_W'({3'b000, term});
        mb = OPND_W'({4'b0000, g});
      end
      S_TREC: begin
        ma = OPND_W'({3'b000, prod[60:30]});
        mb = OPND_W'({2'b00, recip(n)});
      end
      S_WLO: begin
        ma = OPND_W'({3'b000, ex});
        mb = OPND_W'({11'd0, esq[22:0]});
      end
      S_WHI: begin
        ma = OPND_W'({3'b000, ex});
        mb = OPND_W'({10'd0, esq[46:23]});
      end
      S_P: begin
        ma = OPND_W'({18'd0, u});
        mb = OPND_W'(34'd65536 - 34'(u));
      end
      S_UU: begin
        ma = OPND_W'({18'd0, u});
        mb = OPND_W'({18'd0, u});
      end
      S_UUU: begin
        ma = OPND_W'({18'd0, prod[31:16]});
        mb = OPND_W'({18'd0, u});
      end
      S_CP: begin
        ma = OPND_W'({2'b00, c});
        mb = OPND_W'({18'd0, p});
      end
      S_CU: begin
        ma = OPND_W'({2'b00, c});
        mb = OPND_W'({18'd0, u});
      end
      S_D3: begin
        ma = OPND_W'({2'b00, cp});
        mb = OPND_W'(q3);
      end
      S_D4: begin
        ma = OPND_W'({2'b00, cp});
        mb = OPND_W'(q4);
      end
      S_D5: begin
        ma = OPND_W'({2'b00, cp});
        mb = OPND_W'(q5);
      end
      default: begin
        launch = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      prod <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      dof <= DOF_RESET;
      ar_a <= '0;
      ar_b <= '0;
      prev_obs <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEGREES_FREEDOM: dof <= cfg_data;
          REG_AR_CONSTANT: ar_a <= cfg_data;
          REG_AR_COEFFICIENT: ar_b <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_FIN && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            y <= observation;
            alpha <= log_variance;
            prev <= first_sample ? 32'sd0 : prev_obs;
            prev_obs <= observation;
            state <= S_BP;
          end
        end
        S_BP: state <= S_RES;
        S_RES: begin
          e <= sat32(resid);
          state <= S_SQ;
        end
        S_SQ: state <= S_T;
        S_T: begin
          esq <= prod[62:16];
          state <= S_G;
        end
        S_G: begin
          k <= prod[63:46];
          state <= S_TG;
        end
        S_TG: begin
          g <= prod[59:30];
          term <= 31'd1 << 30;
          sum <= 32'd1 << 30;
          n <= 4'd1;
          state <= S_TMUL;
        end
        S_TMUL: state <= S_TREC;
        S_TREC: begin
          xr <= prod[60:30];
          state <= S_TCOR;
        end
        S_TCOR: begin
          term <= term_new;
          sum <= sum + 32'(term_new);
          n <= n + 4'd1;
          state <= (n == 4'(TAYLOR_TERMS)) ? S_SCALE : S_TMUL;
        end
        S_SCALE: begin
          ex <= ex_new;
          state <= S_WLO;
        end
        S_WLO: state <= S_WHI;
        S_WHI: begin
          acc <= prod;
          state <= S_WSUM;
        end
        S_WSUM: begin
          den <= 63'(nu) + w;
          rem <= 64'(w);
          u <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem2 >= 64'(den)) begin
            rem <= rem2 - 64'(den);
            u <= {u[14:0], 1'b1};
          end else begin
            rem <= rem2;
            u <= {u[14:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_P;
          end
        end
        S_P: state <= S_UU;
        S_UU: begin
          p <= prod[31:16];
          state <= S_UUU;
        end
        S_UUU: begin
          uu <= prod[31:16];
          state <= S_CP;
        end
        S_CP: begin
          uuu <= prod[31:16];
          state <= S_CU;
        end
        S_CU: begin
          cp <= prod[47:16];
          state <= S_D3;
        end
        S_D3: begin
          d1 <= sat32(prod_asr - 68'sd32768);
          state <= S_D4;
        end
        S_D4: begin
          d3 <= sat32(prod_asr);
          state <= S_D5;
        end
        S_D5: begin
          d4 <= sat32(-prod_asr);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            deriv_first <= d1;
            deriv_second <= sat32(-PROD_W'({1'b0, cp}));
            deriv_third <= d3;
            deriv_fourth <= d4;
            deriv_fifth <= sat32(prod_asr);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/stsd_checker.sv
`default_nettype none

module stsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [31:0] cfg_data,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic [31:0] observation,
  input wire logic [31:0] log_variance,
  input wire logic        first_sample,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [31:0] deriv_first,
  input wire logic [31:0] deriv_second,
  input wire logic [31:0] deriv_third,
  input wire logic [31:0] deriv_fourth,
  input wire logic [31:0] deriv_fifth
);

  // A pending result keeps its value until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(deriv_first)
      && $stable(deriv_fifth))
    else $error("pending result changed");

  // The block is busy in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready && !result_valid || !item_ready)
    else $error("input taken while busy");

  // No result can appear right after an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> !result_valid)
    else $error("result without work");

  // The second derivative is never positive.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> deriv_second[31] || deriv_second == 32'd0)
    else $error("second derivative positive");

  // Reset leaves no result pending.
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind student_t_sv_score_derivatives stsd_checker u_stsd_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stsd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint unsigned SCORE_W_CAP = 64'd1 << 62;

  typedef struct packed {
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] d3;
    logic signed [31:0] d4;
    logic signed [31:0] d5;
  } score_set_t;

  typedef struct packed {
    logic signed [31:0] obs;
    logic signed [31:0] lvar;
    logic               first;
    logic               known;
    score_set_t         score;
  } score_row_t;

  localparam score_set_t ZERO_SCORE = '{-32'sd32768, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam score_set_t NO_SCORE = '0;

  localparam score_row_t SCORE_ROWS [0:14] = '{
    '{32'h00000000, 32'h00000000, 1'b1, 1'b1, ZERO_SCORE},
    '{32'h00000000, 32'h7FFFFFFF, 1'b1, 1'b1, ZERO_SCORE},
    '{32'h00000000, 32'h80000000, 1'b1, 1'b1, ZERO_SCORE},
    '{32'h00010000, 32'h00000000, 1'b0, 1'b0, NO_SCORE},
    '{32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, NO_SCORE},
    '{32'h80000000, 32'h80000000, 1'b0, 1'b0, NO_SCORE},
    '{32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, NO_SCORE},
    '{32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b0, NO_SCORE},
    '{32'h00010000, 32'hFFFF0000, 1'b1, 1'b0, NO_SCORE},
    '{32'h00020000, 32'h00010000, 1'b0, 1'b0, NO_SCORE},
    '{32'hFFFF8000, 32'h00000000, 1'b0, 1'b0, NO_SCORE},
    '{32'h00030000, 32'hFFF60000, 1'b1, 1'b0, NO_SCORE},
    '{32'h00000000, 32'h00000000, 1'b1, 1'b1, ZERO_SCORE},
    '{32'h55555555, 32'hAAAAAAAA, 1'b0, 1'b0, NO_SCORE},
    '{32'hAAAAAAAA, 32'h55555555, 1'b1, 1'b0, NO_SCORE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [31:0] observation = '0;
  logic signed [31:0] log_variance = '0;
  logic first_sample = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [31:0] deriv_first, deriv_second, deriv_third, deriv_fourth, deriv_fifth;

  student_t_sv_score_derivatives uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .observation(observation),
    .log_variance(log_variance), .first_sample(first_sample),
    .result_valid(result_valid), .result_ready(result_ready),
    .deriv_first(deriv_first), .deriv_second(deriv_second), .deriv_third(deriv_third),
    .deriv_fourth(deriv_fourth), .deriv_fifth(deriv_fifth)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [31:0] model_dof;
  logic signed [31:0] model_const;
  logic signed [31:0] model_coef;
  logic signed [31:0] model_prev;

  score_set_t pending_scores [$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  bit pressure_done = 1'b0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned exp_q(input longint z);
    longint t, k, s;
    longint unsigned fr, g, term, sum;
    t = z * longint'(LOG2E_Q30);
    k = t >>> (FRAC_BITS + 30);
    fr = longint'(t & 64'sh3FFF_FFFF_FFFF);
    fr = fr >> FRAC_BITS;
    g = (fr * longint'(LN2_Q30)) >> 30;
    term = 64'd1 << 30;
    sum = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * g) >> 30) / n;
      sum += term;
    end
    s = k + FRAC_BITS - 30;
    if (s >= 0) begin
      if (s >= 31 || sum > (64'h7FFFFFFF >> s)) return 64'h7FFFFFFF;
      return sum << s;
    end
    if (-s >= 40) return 0;
    return sum >> (-s);
  endfunction

  function automatic score_set_t predict_score(input logic signed [31:0] obs,
                                               input logic signed [31:0] lvar,
                                               input logic first);
    longint y, prev, e, u, p, c, uu, uuu, cp, q3, q4, q5;
    longint unsigned nu, mag, esq, ex, w, den, rem, q;
    score_set_t r;
    y = longint'(obs);
    prev = first ? 0 : longint'(model_prev);
    nu = (model_dof != 0) ? longint'(model_dof) : 1;
    e = longint'(clamp32(y - longint'(model_const)
                         - ((longint'(model_coef) * prev) >>> FRAC_BITS)));
    model_prev = obs;
    mag = (e < 0) ? -e : e;
    esq = (mag * mag) >> FRAC_BITS;
    ex = exp_q(-longint'(lvar));
    if (esq == 0) w = 0;
    else if (ex > SCORE_W_CAP / esq) w = SCORE_W_CAP;
    else w = (ex * esq) >> FRAC_BITS;
    den = nu + w;
    rem = w;
    q = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    u = longint'(q);
    p = (u * (65536 - u)) >>> FRAC_BITS;
    c = longint'((nu + 64'd65536) >> 1);
    uu = (u * u) >>> FRAC_BITS;
    uuu = (uu * u) >>> FRAC_BITS;
    cp = (c * p) >>> FRAC_BITS;
    q3 = 65536 - 2 * u;
    q4 = 65536 - 6 * u + 6 * uu;
    q5 = 65536 - 14 * u + 36 * uu - 24 * uuu;
    r.d1 = clamp32(((c * u) >>> FRAC_BITS) - 32768);
    r.d2 = clamp32(-cp);
    r.d3 = clamp32((cp * q3) >>> FRAC_BITS);
    r.d4 = clamp32(-((cp * q4) >>> FRAC_BITS));
    r.d5 = clamp32((cp * q5) >>> FRAC_BITS);
    return r;
  endfunction

  task automatic send_item(input logic signed [31:0] obs, input logic signed [31:0] lvar,
                           input logic first, input bit known, input score_set_t typed);
    score_set_t s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    observation <= obs;
    log_variance <= lvar;
    first_sample <= first;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
    s = predict_score(obs, lvar, first);
    pending_scores.push_back(known ? typed : s);
    items_sent++;
  endtask

  task automatic drain_scores();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_DEGREES_FREEDOM: model_dof = val;
      REG_AR_CONSTANT: model_const = val;
      REG_AR_COEFFICIENT: model_coef = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(input int count);
    logic signed [31:0] obs, lvar;
    logic first;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        obs = $urandom;
        lvar = $urandom;
        first = 1'($urandom_range(0, 1));
      end else begin
        obs = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
        lvar = $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
        first = ($urandom_range(0, 15) == 0);
      end
      send_item(obs, lvar, first, 1'b0, NO_SCORE);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  int stall_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (!pressure_done && items_sent >= 700) begin
      pressure_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 3) != 0);
        2: result_ready <= 1'($urandom_range(0, 1));
        default: result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(negedge clk) begin
    score_set_t got, want;
    if (!rst && result_valid && result_ready) begin
      got = '{deriv_first, deriv_second, deriv_third, deriv_fourth, deriv_fifth};
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %h", got);
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Score mismatch: d1 %0d/%0d d2 %0d/%0d d3 %0d/%0d d4 %0d/%0d d5 %0d/%0d",
                     want.d1, got.d1, want.d2, got.d2, want.d3, got.d3,
                     want.d4, got.d4, want.d5, got.d5);
          end
        end
      end
    end
  end

  initial begin
    model_dof = DOF_RESET;
    model_const = '0;
    model_coef = '0;
    model_prev = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCORE_ROWS[i]) begin
      send_item(SCORE_ROWS[i].obs, SCORE_ROWS[i].lvar, SCORE_ROWS[i].first,
                SCORE_ROWS[i].known, SCORE_ROWS[i].score);
    end
    random_items(300);
    drain_scores();

    write_reg(REG_DEGREES_FREEDOM, 32'd1);
    write_reg(REG_AR_CONSTANT, 32'h00008000);
    write_reg(REG_AR_COEFFICIENT, 32'h0000E666);
    random_items(300);
    drain_scores();

    write_reg(REG_DEGREES_FREEDOM, 32'd0);
    write_reg(REG_AR_CONSTANT, 32'h80000000);
    write_reg(REG_AR_COEFFICIENT, 32'h7FFFFFFF);
    random_items(250);
    drain_scores();

    write_reg(REG_DEGREES_FREEDOM, 32'hFFFFFFFF);
    write_reg(REG_AR_CONSTANT, 32'h7FFFFFFF);
    write_reg(REG_AR_COEFFICIENT, 32'h80000000);
    random_items(250);
    drain_scores();

    write_reg(REG_SPARE, $urandom);
    write_reg(REG_DEGREES_FREEDOM, $urandom_range(32'h00010000, 32'h00200000));
    write_reg(REG_AR_CONSTANT, $urandom);
    write_reg(REG_AR_COEFFICIENT, $signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000);
    random_items(500);
    drain_scores();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
